@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the hash table engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock while out of reset.
`define CHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked while out of reset.
`define CHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// cht_pkg
// Shared constants and types of the hash table engine.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int unsigned CHT_SLOTS = 64;
  localparam int unsigned KEY_W = 31;
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned IDX_OUT_W = 6;

  localparam logic [1:0] CMD_LIN = 2'd0;
  localparam logic [1:0] CMD_QUAD = 2'd1;
  localparam logic [1:0] CMD_DBL = 2'd2;
  localparam logic [1:0] CMD_REM = 2'd3;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

endpackage

@@ hw/rtl/closed_hash_table_engine.sv @@
// ----------------------------------------------------------------------------
// closed_hash_table_engine
// Open-addressing hash table with linear, quadratic, double-hash insert and
// stride-walk remove, keys held in a single-port synchronous memory.
// ----------------------------------------------------------------------------
// Each item runs a bit-serial key mod n and 7*key mod (n-1), then a memory read and then
// a compare and write for each probe walked, and then the output word is posted.
// One item at a time: in_ready rises once the word is posted, and S_OUT holds while a
// posted word still waits for out_ready.
// Reset (rst_n, synchronous) clears the used and live maps at once and sets
// table_size to 64; the key memory is not cleared.
`include "assert_macros.svh"

module closed_hash_table_engine
  import cht_pkg::*;
#(
  parameter int unsigned SLOTS = CHT_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [SIZE_W-1:0]    cfg_table_size,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic [KEY_W-1:0]     in_key,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [IDX_OUT_W-1:0] out_slot_index
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // Width that holds the value SLOTS itself and any table_size.
  localparam int unsigned NW = ((AW + 1) > SIZE_W) ? (AW + 1) : SIZE_W;
  localparam int unsigned CW = $clog2(KEY_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [SIZE_W-1:0] size_r;
  logic [2:0]        state_r, state_nxt;

  logic [1:0]        cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [NW-1:0]     n_r, nm1;
  logic [CW-1:0]     bit_r;
  // Remainders of key mod n and (7*key) mod (n-1), computed one key bit a cycle.
  logic [NW-1:0]     rem_h_r, rem_s_r;
  logic [NW-1:0]     home_r, idx_r, off_r, stride_r, dstep_r, probe_r, qinc_r;

  logic [KEY_W-1:0]  slot_key_mem [SLOTS];
  logic [KEY_W-1:0]  rd_key_r;
  logic [SLOTS-1:0]  used_r, live_r;

  // The finished result waits in fin_* until the output word is free.
  logic [1:0]           fin_status_r;
  logic [IDX_OUT_W-1:0] fin_idx_r;
  logic [1:0]           res_status_r;
  logic [IDX_OUT_W-1:0] res_idx_r;

  logic [NW-1:0] n_eff;
  always_comb begin
    n_eff = NW'(size_r);
    if (n_eff < NW'(2)) n_eff = NW'(2);
    if (n_eff > NW'(SLOTS)) n_eff = NW'(SLOTS);
  end
  assign nm1 = n_r - NW'(1);

  // One restoring step: rem = (2*rem + b) mod m, with rem < m.
  function automatic logic [NW-1:0] mod_step(input logic [NW-1:0] rem, input logic b,
                                             input logic [NW-1:0] m);
    logic [NW:0] t;
    t = {rem, b};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[NW-1:0];
  endfunction

  // Add two values below m, result mod m.
  function automatic logic [NW-1:0] add_mod(input logic [NW-1:0] a, input logic [NW-1:0] b,
                                            input logic [NW-1:0] m);
    logic [NW:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[NW-1:0];
  endfunction

  // Key mod 7 from its octal digits, since 8 mod 7 is 1.
  function automatic logic [2:0] mod7(input logic [KEY_W-1:0] k);
    logic [32:0] kp;
    logic [6:0]  s;
    logic [3:0]  t;
    logic [3:0]  u;
    logic [2:0]  v;
    kp = 33'(k);
    s = '0;
    for (int i = 0; i < 11; i++) s = s + 7'(kp[3*i +: 3]);
    t = 4'(s[6]) + 4'(s[5:3]) + 4'(s[2:0]);
    u = 4'(t[3]) + 4'(t[2:0]);
    v = u[2:0] + 3'(u[3]);
    return (v == 3'd7) ? 3'd0 : v;
  endfunction

  logic          kb;
  logic [NW-1:0] s1;
  always_comb begin
    kb = key_r[bit_r[CW-1:0] - CW'(1)];
    // 7*key shifted in bitwise: rem_s = 2*rem_s + 7*b, reduced mod (n-1).
    s1 = mod_step(rem_s_r, 1'b0, nm1);
  end
  // 7 mod (n-1), where n-1 may be as small as 1.
  logic [NW-1:0] seven_mod;
  always_comb begin
    seven_mod = NW'(7);
    if (seven_mod >= nm1) seven_mod = seven_mod - nm1;
    if (seven_mod >= nm1) seven_mod = seven_mod - nm1;
    if (seven_mod >= nm1) seven_mod = seven_mod - nm1;
    if (seven_mod >= nm1) seven_mod = seven_mod - nm1;
    if (seven_mod >= nm1) seven_mod = seven_mod - nm1;
    if (seven_mod >= nm1) seven_mod = NW'(0);
  end
  logic [NW-1:0] rem_s_nxt;
  assign rem_s_nxt = kb ? add_mod(s1, seven_mod, nm1) : s1;

  logic slot_free, key_hit, probe_last;
  assign slot_free  = !used_r[idx_r[AW-1:0]] || !live_r[idx_r[AW-1:0]];
  assign key_hit    = (rd_key_r == key_r);
  assign probe_last = (probe_r == nm1);

  logic [NW-1:0] next_idx_rem;
  assign next_idx_rem = add_mod(idx_r, stride_r, n_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) state_nxt = S_DIV;
      S_DIV:  if (bit_r == CW'(1)) state_nxt = S_RD;
      S_RD:   state_nxt = S_CHK;
      S_CHK: begin
        if (cmd_r == CMD_REM) begin
          if (!used_r[idx_r[AW-1:0]] || key_hit || next_idx_rem == home_r || probe_last)
            state_nxt = S_OUT;
          else state_nxt = S_RD;
        end else if (slot_free || probe_last) state_nxt = S_OUT;
        else state_nxt = S_RD;
      end
      S_OUT:  if (!out_valid || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  logic out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_status     = res_status_r;
  assign out_slot_index = res_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_W'(64);
      state_r     <= S_IDLE;
      used_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) size_r <= cfg_table_size;
      if (state_r == S_OUT && state_nxt == S_IDLE) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == S_CHK && cmd_r != CMD_REM && slot_free) begin
        used_r[idx_r[AW-1:0]] <= 1'b1;
        live_r[idx_r[AW-1:0]] <= 1'b1;
      end
      if (state_r == S_CHK && cmd_r == CMD_REM && used_r[idx_r[AW-1:0]] && key_hit)
        live_r[idx_r[AW-1:0]] <= 1'b0;
    end
  end

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state_r == S_RD) rd_key_r <= slot_key_mem[idx_r[AW-1:0]];
    if (state_r == S_CHK && cmd_r != CMD_REM && slot_free)
      slot_key_mem[idx_r[AW-1:0]] <= key_r;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        cmd_r   <= in_cmd;
        key_r   <= in_key;
        n_r     <= n_eff;
        bit_r   <= CW'(KEY_W);
        rem_h_r <= '0;
        rem_s_r <= '0;
      end
      S_DIV: begin
        bit_r   <= bit_r - CW'(1);
        rem_h_r <= mod_step(rem_h_r, kb, n_r);
        rem_s_r <= (nm1 == NW'(1)) ? '0 : rem_s_nxt;
        if (bit_r == CW'(1)) begin
          home_r   <= mod_step(rem_h_r, kb, n_r);
          idx_r    <= mod_step(rem_h_r, kb, n_r);
          stride_r <= ((nm1 == NW'(1)) ? NW'(0) : rem_s_nxt) + NW'(1);
          dstep_r  <= NW'(7) - NW'(mod7(key_r));
          probe_r  <= '0;
          off_r    <= '0;
          qinc_r   <= NW'(1);
        end
      end
      S_CHK: begin
        probe_r <= probe_r + NW'(1);
        if (cmd_r == CMD_REM) begin
          idx_r <= next_idx_rem;
        end else begin
          // Offsets kept reduced mod n: linear +1, quadratic +(2p+1), double +s.
          logic [NW-1:0] inc;
          logic [NW-1:0] noff;
          inc = (cmd_r == CMD_LIN) ? NW'(1)
              : (cmd_r == CMD_QUAD) ? qinc_r
              : dstep_r;
          if (inc >= n_r) inc = inc - n_r;
          if (inc >= n_r) inc = inc - n_r;
          if (inc >= n_r) inc = inc - n_r;
          if (inc >= n_r) inc = inc - n_r;
          noff = add_mod(off_r, inc, n_r);
          off_r  <= noff;
          qinc_r <= add_mod(add_mod(qinc_r >= n_r ? qinc_r - n_r : qinc_r, NW'(2) >= n_r
                            ? NW'(0) : NW'(2), n_r), '0, n_r);
          idx_r  <= add_mod(home_r, noff, n_r);
        end
        if (state_nxt == S_OUT) begin
          if (cmd_r == CMD_REM) begin
            if (used_r[idx_r[AW-1:0]] && key_hit) begin
              fin_status_r <= ST_REMOVED;
              fin_idx_r    <= IDX_OUT_W'(idx_r);
            end else begin
              fin_status_r <= ST_NOTFOUND;
              fin_idx_r    <= '0;
            end
          end else if (slot_free) begin
            fin_status_r <= ST_INSERTED;
            fin_idx_r    <= IDX_OUT_W'(idx_r);
          end else begin
            fin_status_r <= ST_FULL;
            fin_idx_r    <= '0;
          end
        end
      end
      S_OUT: begin
        // The output word only changes when it is posted.
        if (state_nxt == S_IDLE) begin
          res_status_r <= fin_status_r;
          res_idx_r    <= fin_idx_r;
        end
      end
      default: ;
    endcase
  end

  `CHT_ASSERT_IMP(a_probe_in_range, clk, rst_n, state_r == S_CHK, idx_r < n_r)
  `CHT_ASSERT_NXT(a_out_after_post, clk, rst_n, state_r == S_OUT && state_nxt == S_IDLE,
                  out_valid)
  `CHT_ASSERT_IMP(a_ready_idle_only, clk, rst_n, in_ready, state_r == S_IDLE)

endmodule
